>>> rtl/core/pem_pkg.sv
// ----------------------------------------------------------------------------
// pem_pkg
// shared widths, codes, queue entry and control types of the energy meter
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int TIME_W     = 32;
  localparam int DAY_W      = 3;
  localparam int ROT_W      = 16;
  localparam int ENERGY_W   = 41;
  localparam int POWER_W    = 32;
  localparam int PROD_W     = ROT_W + TIME_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ENERGY_W;

  localparam int ENERGY_FRACTION_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF          = 4;

  localparam logic [ROT_W-1:0]   ROT_RESET        = 16'd75;
  localparam logic [POWER_W-1:0] POWER_NUMERATOR  = 32'd3600000000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX      = {ENERGY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATIONS     = 1'b0,
    REG_INITIAL_TOTAL = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_STEP_GO,
    B_STEP_WAIT,
    B_POW_GO,
    B_POW_WAIT,
    B_OUT
  } back_state_e;

  // one classified sample between front and back
  typedef struct packed {
    logic              measure;
    logic              new_day;
    logic [TIME_W-1:0] elapsed;
  } q_entry_t;

  typedef struct packed {
    logic rot_we;
    logic total_we;
  } cfg_ctl_t;

  function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] a,
                                                  input logic [ENERGY_W-1:0] b);
    logic [ENERGY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_W] ? ENERGY_MAX : s[ENERGY_W-1:0];
  endfunction

endpackage

>>> rtl/core/pem_if.sv
// ----------------------------------------------------------------------------
// pem_if
// sample and result channels of the energy meter, valid/ready handshake
// ----------------------------------------------------------------------------
interface pem_in_if import pem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              sensor_low;
  logic [TIME_W-1:0] time_seconds;
  logic [DAY_W-1:0]  weekday;

  modport source (output valid, sensor_low, time_seconds, weekday, input ready);
  modport sink   (input valid, sensor_low, time_seconds, weekday, output ready);
endinterface

interface pem_out_if import pem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POWER_W-1:0]  power_milliwatts;
  logic [ENERGY_W-1:0] total_energy;
  logic [ENERGY_W-1:0] today_energy;
  logic                updated;

  modport source (output valid, power_milliwatts, total_energy, today_energy, updated,
                  input ready);
  modport sink   (input valid, power_milliwatts, total_energy, today_energy, updated,
                  output ready);
endinterface

>>> rtl/core/pulse_energy_meter.sv
// ----------------------------------------------------------------------------
// pulse_energy_meter
// disc sensor energy meter: power in mW, total and daily energy in fixed point
// ----------------------------------------------------------------------------
// a sample that measures nothing is popped and loaded straight into the result word;
// a measuring sample passes B_MUL, the energy step divide (after reset or a rotations
// write), the power divide with a NumW bit quotient, NumW = 32 for fraction bits up
// to 31, and B_OUT, one sample at a time; both divides share one iterative divider
// reset: asynchronous, active low; sums and power clear, rotations reads 75
module pulse_energy_meter import pem_pkg::*; #(
  parameter int ENERGY_FRACTION_BITS = ENERGY_FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH          = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pem_in_if.sink                in_ch,
  pem_out_if.source             out_ch
);

  // configuration: rotations kept here, initial total goes straight to the sum
  logic [ROT_W-1:0] rot_q;
  cfg_ctl_t         cfg_ctl;

  assign cfg_ctl.rot_we   = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_ROTATIONS);
  assign cfg_ctl.total_we = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_INITIAL_TOTAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_RESET;
    end else if (cfg_ctl.rot_we) begin
      rot_q <= cfg_data_i[ROT_W-1:0];
    end
  end

  // front to back queue of classified samples
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_pop, q_full, q_empty;

  // front: edge detect, arming, timestamp and weekday tracking
  pem_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_entry_o(q_wdata)
  );

  pem_fifo #(.WIDTH($bits(q_entry_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // back: multiply, divide, saturating sums, output register
  pem_back #(.ENERGY_FRACTION_BITS(ENERGY_FRACTION_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ctl),
    .rot_i    (rot_q),
    .total_i  (cfg_data_i),
    .q_empty_i(q_empty),
    .q_entry_i(q_rdata),
    .q_pop_o  (q_pop),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/core/pem_fifo.sv
// ----------------------------------------------------------------------------
// pem_fifo
// small register queue between front and back
// ----------------------------------------------------------------------------
module pem_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/pem_div.sv
// ----------------------------------------------------------------------------
// pem_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pem_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CntW-1:0] CntTop = CntW'(NUM_W - 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] q_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, q_q[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntTop;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      q_q   <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_q   <= {q_q[NUM_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/pem_front.sv
// ----------------------------------------------------------------------------
// pem_front
// takes sensor samples, tracks edge and time state, classifies each sample
// ----------------------------------------------------------------------------
module pem_front import pem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pem_in_if.sink    in_ch,
  input  logic      q_full_i,
  output logic      q_push_o,
  output q_entry_t  q_entry_o
);

  logic              prev_q, armed_q;
  logic [TIME_W-1:0] last_time_q;
  logic [DAY_W-1:0]  last_day_q;
  logic              accept, active;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = !in_ch.sensor_low;
  assign q_push_o    = accept;

  always_comb begin
    q_entry_o.measure = active && !prev_q && armed_q && (in_ch.time_seconds > last_time_q);
    q_entry_o.new_day = (last_day_q != in_ch.weekday);
    q_entry_o.elapsed = in_ch.time_seconds - last_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      armed_q     <= 1'b0;
      last_time_q <= '0;
      last_day_q  <= '0;
    end else if (accept) begin
      prev_q <= active;
      if (active) begin
        if (last_time_q == '0) begin
          armed_q <= 1'b1;
        end
        last_time_q <= in_ch.time_seconds;
        last_day_q  <= in_ch.weekday;
      end
    end
  end

endmodule

>>> rtl/core/pem_back.sv
// ----------------------------------------------------------------------------
// pem_back
// computes power and energy for each measuring sample and drives a result word per classified sample
// ----------------------------------------------------------------------------
module pem_back import pem_pkg::*; #(
  parameter int ENERGY_FRACTION_BITS = ENERGY_FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_ctl_t            cfg_i,
  input  logic [ROT_W-1:0]    rot_i,
  input  logic [ENERGY_W-1:0] total_i,
  input  logic                q_empty_i,
  input  q_entry_t            q_entry_i,
  output logic                q_pop_o,
  pem_out_if.source           out_ch
);

  localparam int NumW = (ENERGY_FRACTION_BITS >= POWER_W) ? ENERGY_FRACTION_BITS + 1 : POWER_W;
  localparam logic [NumW-1:0] OneFix = {{(NumW-1){1'b0}}, 1'b1} << ENERGY_FRACTION_BITS;

  back_state_e state_q, state_d;

  logic [ENERGY_W-1:0] energy_q, day_q, e_new, d_new, step_e;
  logic [POWER_W-1:0]  power_q;
  logic [ENERGY_W-1:0] step_q;
  logic                step_ok_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic                new_day_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ROT_W-1:0]    rot_eff;

  logic                out_valid_q, out_upd_q;
  logic [POWER_W-1:0]  out_pow_q;
  logic [ENERGY_W-1:0] out_tot_q, out_day_q;

  logic                can_load, load_plain, load_meas, div_start, sel_step, div_done;
  logic [NumW-1:0]     div_num, div_quot;
  logic [PROD_W-1:0]   div_den;

  assign rot_eff  = (rot_i == '0) ? ROT_W'(1) : rot_i;
  assign can_load = !out_valid_q || out_ch.ready;
  assign step_e   = step_q;
  assign e_new    = sat_add(energy_q, step_e);
  assign d_new    = sat_add(new_day_q ? '0 : day_q, step_e);

  // step numerator 2^F + rot/2, power numerator fixed
  assign div_num = sel_step ? (OneFix + NumW'(rot_eff >> 1)) : NumW'(POWER_NUMERATOR);
  assign div_den = sel_step ? PROD_W'(rot_eff) : prod_q;

  pem_div #(.NUM_W(NumW), .DEN_W(PROD_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i && q_entry_i.measure) state_d = B_MUL;
      end
      B_MUL:       state_d = step_ok_q ? B_POW_GO : B_STEP_GO;
      B_STEP_GO:   state_d = B_STEP_WAIT;
      B_STEP_WAIT: if (div_done) state_d = B_POW_GO;
      B_POW_GO:    state_d = B_POW_WAIT;
      B_POW_WAIT:  if (div_done) state_d = B_OUT;
      B_OUT:       if (can_load) state_d = B_IDLE;
      default:     state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    load_plain = 1'b0;
    load_meas  = 1'b0;
    div_start  = 1'b0;
    sel_step   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.measure) begin
            q_pop_o = 1'b1;
          end else if (can_load) begin
            q_pop_o    = 1'b1;
            load_plain = 1'b1;
          end
        end
      end
      B_STEP_GO: begin
        div_start = 1'b1;
        sel_step  = 1'b1;
      end
      B_POW_GO:  div_start = 1'b1;
      B_OUT:     load_meas = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      energy_q    <= '0;
      day_q       <= '0;
      power_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.rot_we) begin
        step_ok_q <= 1'b0;
      end else if (state_q == B_STEP_WAIT && div_done) begin
        step_ok_q <= 1'b1;
      end
      if (cfg_i.total_we) begin
        energy_q <= total_i;
      end else if (load_meas) begin
        energy_q <= e_new;
      end
      if (load_meas) begin
        day_q <= d_new;
      end
      if (state_q == B_POW_WAIT && div_done) begin
        power_q <= div_quot[POWER_W-1:0];
      end
      if (load_plain || load_meas) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && q_pop_o) begin
      elapsed_q <= q_entry_i.elapsed;
      new_day_q <= q_entry_i.new_day;
    end
    if (state_q == B_MUL) begin
      prod_q <= PROD_W'(rot_eff) * PROD_W'(elapsed_q);
    end
    if (state_q == B_STEP_WAIT && div_done) begin
      step_q <= ENERGY_W'(div_quot);
    end
    if (load_plain) begin
      out_pow_q <= power_q;
      out_tot_q <= energy_q;
      out_day_q <= day_q;
      out_upd_q <= 1'b0;
    end else if (load_meas) begin
      out_pow_q <= power_q;
      out_tot_q <= e_new;
      out_day_q <= d_new;
      out_upd_q <= 1'b1;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.power_milliwatts = out_pow_q;
  assign out_ch.total_energy     = out_tot_q;
  assign out_ch.today_energy     = out_day_q;
  assign out_ch.updated          = out_upd_q;

endmodule

>>> rtl/core/pem_checker.sv
// ----------------------------------------------------------------------------
// pem_checker
// port level checks on the result channel of the energy meter
// ----------------------------------------------------------------------------
module pem_checker import pem_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [POWER_W-1:0]  power_i,
  input logic [ENERGY_W-1:0] total_i,
  input logic                updated_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(total_i) && $stable(updated_i))
    else $error("stalled result word changed");

  a_power_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> power_i <= POWER_NUMERATOR)
    else $error("power above largest possible value");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result word valid during reset");

endmodule

bind pulse_energy_meter pem_checker u_pem_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .power_i    (out_ch.power_milliwatts),
  .total_i    (out_ch.total_energy),
  .updated_i  (out_ch.updated)
);
